// File: hdl/spv_pkg.sv
package spv_pkg;

    // Level count and derived widths
    localparam int NUM_LEVELS = 8;
    localparam int LVL_W      = (NUM_LEVELS > 2) ? $clog2(NUM_LEVELS) : 1;
    localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(NUM_LEVELS - 1);

    // Field widths
    localparam int RES_W  = 24;
    localparam int TOL_W  = 16;
    localparam int AMP_W  = 15;
    localparam int MAG_W  = 14;
    localparam int STEP_W = 10;
    localparam int HIT_W  = 16;
    localparam int ACT_W  = 2;
    localparam int LIDX_W = 4;

    // Shared multiplier: 24 x 16
    localparam int MUL_A_W = 24;
    localparam int MUL_B_W = 16;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_LOW_RES   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_RES  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POS_START = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NEG_START = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP      = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_AMP   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HITS      = 4'd7;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_NONE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_POS  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_NEG  = 2'd2;

    // Datapath step codes
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NONE     = 3'd0;
    localparam logic [OP_W-1:0] OP_MUL_LOW  = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL_HIGH = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL_RD   = 3'd3;
    localparam logic [OP_W-1:0] OP_MUL_TLO  = 3'd4;
    localparam logic [OP_W-1:0] OP_MUL_THI  = 3'd5;
    localparam logic [OP_W-1:0] OP_ACC      = 3'd6;
    localparam logic [OP_W-1:0] OP_WIN      = 3'd7;

    // Controller -> datapath
    typedef struct packed {
        logic            load;
        logic [OP_W-1:0] op;
        logic            judge;
    } spv_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic finished;
        logic out_free;
    } spv_stat_t;

endpackage

// File: hdl/step_pulse_program_verify.sv
// Program-and-verify controller for a multilevel resistive cell. Each item is one
// verify-read resistance; each yields one result item telling whether to apply a
// positive pulse, a negative pulse or none, at what amplitude, and whether the
// current level (or the whole sequence) is done. An item is accepted in idle and
// its result is written to the output register after the steps of the single
// shared 24x16 multiplier, which forms the five products of the window test
// (target terms, scaled reading, tolerance terms) one per cycle, a step to
// accumulate, a step to form the window bounds and a judge step that waits for a
// free output register. Once every level is programmed the arithmetic is skipped.
// A new item is accepted while a finished result still waits in the output register.
// Configuration writes take effect at once and are meant for idle periods.
module step_pulse_program_verify
    import spv_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [RES_W-1:0]        s_measured_ohms,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [ACT_W-1:0]        m_action,
    output logic signed [AMP_W-1:0] m_pulse_mv,
    output logic [LIDX_W-1:0]       m_level_index,
    output logic                    m_level_done,
    output logic                    m_all_done
);

    spv_cmd_t  cmd;
    spv_stat_t stat;

    // Sequencer
    spv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Arithmetic, state and result register
    spv_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_measured_ohms (s_measured_ohms),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_action        (m_action),
        .m_pulse_mv      (m_pulse_mv),
        .m_level_index   (m_level_index),
        .m_level_done    (m_level_done),
        .m_all_done      (m_all_done)
    );

endmodule

// File: hdl/spv_ctrl.sv
module spv_ctrl
    import spv_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  spv_stat_t stat,
    output spv_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MLOW  = 4'd1;
    localparam logic [3:0] S_MHIGH = 4'd2;
    localparam logic [3:0] S_MRD   = 4'd3;
    localparam logic [3:0] S_MTLO  = 4'd4;
    localparam logic [3:0] S_MTHI  = 4'd5;
    localparam logic [3:0] S_ACC   = 4'd6;
    localparam logic [3:0] S_WIN   = 4'd7;
    localparam logic [3:0] S_JUDGE = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_ready = (state_reg == S_IDLE);

    // Step sequencing
    always_comb begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.op     = OP_NONE;
        cmd.judge  = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    // once finished, no arithmetic is needed
                    state_next = stat.finished ? S_JUDGE : S_MLOW;
                end
            end
            S_MLOW: begin
                cmd.op     = OP_MUL_LOW;
                state_next = S_MHIGH;
            end
            S_MHIGH: begin
                cmd.op     = OP_MUL_HIGH;
                state_next = S_MRD;
            end
            S_MRD: begin
                cmd.op     = OP_MUL_RD;
                state_next = S_MTLO;
            end
            S_MTLO: begin
                cmd.op     = OP_MUL_TLO;
                state_next = S_MTHI;
            end
            S_MTHI: begin
                cmd.op     = OP_MUL_THI;
                state_next = S_ACC;
            end
            S_ACC: begin
                cmd.op     = OP_ACC;
                state_next = S_WIN;
            end
            S_WIN: begin
                cmd.op     = OP_WIN;
                state_next = S_JUDGE;
            end
            S_JUDGE: begin
                // wait for the output register to free up
                if (stat.out_free) begin
                    cmd.judge  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hdl/spv_datapath.sv
module spv_datapath
    import spv_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  spv_cmd_t                cmd,
    output spv_stat_t               stat,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic [RES_W-1:0]        s_measured_ohms,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [ACT_W-1:0]        m_action,
    output logic signed [AMP_W-1:0] m_pulse_mv,
    output logic [LIDX_W-1:0]       m_level_index,
    output logic                    m_level_done,
    output logic                    m_all_done
);

    // Configuration registers
    logic [RES_W-1:0]  low_res_reg;
    logic [RES_W-1:0]  high_res_reg;
    logic [TOL_W-1:0]  tol_reg;
    logic [AMP_W-1:0]  pos_start_reg;
    logic [AMP_W-1:0]  neg_start_reg;
    logic [STEP_W-1:0] step_reg;
    logic [MAG_W-1:0]  max_amp_reg;
    logic [HIT_W-1:0]  hits_needed_reg;

    // Control state
    logic [LVL_W-1:0] level_reg,  level_next;
    logic [AMP_W-1:0] pos_amp_reg, pos_amp_next;
    logic [AMP_W-1:0] neg_amp_reg, neg_amp_next;
    logic [HIT_W-1:0] hit_reg,    hit_next;
    logic             fin_reg,    fin_next;

    // Arithmetic payload
    logic [RES_W-1:0]   meas_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [32:0]        td_reg;
    logic [31:0]        rd_reg;
    logic [48:0]        tt_reg;
    logic [49:0]        lo_reg;
    logic [49:0]        hi_reg;

    // Result register
    logic               out_valid_reg, out_valid_next;
    logic [ACT_W-1:0]   out_act_reg;
    logic [AMP_W-1:0]   out_pulse_reg;
    logic [LIDX_W-1:0]  out_lidx_reg;
    logic               out_ldone_reg;
    logic               out_adone_reg;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [49:0]        tdx;
    logic [49:0]        lhs;
    logic               in_win;
    logic               above;
    logic [HIT_W-1:0]   need;
    logic [HIT_W:0]     hit_inc;
    logic               reached;
    logic signed [AMP_W:0] pos_sum;
    logic signed [AMP_W:0] neg_diff;
    logic signed [AMP_W:0] neg_margin;
    logic               pos_below;
    logic               neg_above;
    logic [ACT_W-1:0]   act_next;
    logic [AMP_W-1:0]   pulse_next;
    logic               ldone_next;
    logic               adone_next;
    logic [LVL_W+LIDX_W-1:0] level_ext;

    // Clamp a 16-bit signed value to the 15-bit amplitude range
    function automatic logic [AMP_W-1:0] sat_amp(input logic signed [AMP_W:0] v);
        logic [AMP_W-1:0] r;
        if (v > 16'sd16383) begin
            r = 15'h3FFF;
        end else if (v < -16'sd16384) begin
            r = 15'h4000;
        end else begin
            r = v[AMP_W-1:0];
        end
        return r;
    endfunction

    // Shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_MUL_LOW: begin
                mul_a = low_res_reg;
                mul_b = MUL_B_W'(LVL_LAST - level_reg);
            end
            OP_MUL_HIGH: begin
                mul_a = high_res_reg;
                mul_b = MUL_B_W'(level_reg);
            end
            OP_MUL_RD: begin
                mul_a = meas_reg;
                mul_b = MUL_B_W'(LVL_LAST);
            end
            OP_MUL_TLO: begin
                mul_a = td_reg[23:0];
                mul_b = tol_reg;
            end
            OP_MUL_THI: begin
                mul_a = MUL_A_W'(td_reg[32:24]);
                mul_b = tol_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Products and window bounds, one step per cycle
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (cmd.load) begin
            meas_reg <= s_measured_ohms;
        end
        case (cmd.op)
            OP_MUL_HIGH: td_reg <= {1'b0, prod_reg[31:0]};
            OP_MUL_RD:   td_reg <= td_reg + {1'b0, prod_reg[31:0]};
            OP_MUL_TLO:  rd_reg <= prod_reg[31:0];
            OP_MUL_THI:  tt_reg <= {9'b0, prod_reg};
            OP_ACC:      tt_reg <= tt_reg + {prod_reg[24:0], 24'b0};
            OP_WIN: begin
                lo_reg <= tdx - {1'b0, tt_reg};
                hi_reg <= tdx + {1'b0, tt_reg};
            end
            default: begin
            end
        endcase
    end

    assign tdx = {1'b0, td_reg, 16'b0};
    assign lhs = {2'b0, rd_reg, 16'b0};

    // Classification and state update
    always_comb begin
        in_win  = (lhs >= lo_reg) && (lhs <= hi_reg);
        above   = (lhs > hi_reg);
        need    = (hits_needed_reg == '0) ? HIT_W'(1) : hits_needed_reg;
        hit_inc = {1'b0, hit_reg} + (HIT_W+1)'(1);
        reached = (hit_inc >= {1'b0, need});

        pos_sum    = $signed({pos_amp_reg[AMP_W-1], pos_amp_reg})
                   + $signed({6'b0, step_reg});
        neg_diff   = $signed({neg_amp_reg[AMP_W-1], neg_amp_reg})
                   - $signed({6'b0, step_reg});
        pos_below  = $signed({pos_amp_reg[AMP_W-1], pos_amp_reg})
                   < $signed({2'b0, max_amp_reg});
        neg_margin = $signed({neg_amp_reg[AMP_W-1], neg_amp_reg})
                   + $signed({2'b0, max_amp_reg});
        neg_above  = (neg_margin > 16'sd0);

        level_next   = level_reg;
        pos_amp_next = pos_amp_reg;
        neg_amp_next = neg_amp_reg;
        hit_next     = hit_reg;
        fin_next     = fin_reg;
        act_next     = ACT_NONE;
        pulse_next   = '0;
        ldone_next   = 1'b0;
        adone_next   = fin_reg;

        if (!fin_reg) begin
            if (in_win) begin
                pos_amp_next = pos_start_reg;
                neg_amp_next = neg_start_reg;
                hit_next     = hit_inc[HIT_W-1:0];
                if (reached) begin
                    hit_next   = '0;
                    ldone_next = 1'b1;
                    if (level_reg == LVL_LAST) begin
                        fin_next   = 1'b1;
                        adone_next = 1'b1;
                    end else begin
                        level_next = level_reg + LVL_W'(1);
                    end
                end
            end else if (above) begin
                act_next     = ACT_POS;
                pulse_next   = pos_amp_reg;
                if (pos_below) begin
                    pos_amp_next = sat_amp(pos_sum);
                end
                neg_amp_next = neg_start_reg;
            end else begin
                act_next     = ACT_NEG;
                pulse_next   = neg_amp_reg;
                if (neg_above) begin
                    neg_amp_next = sat_amp(neg_diff);
                end
                pos_amp_next = pos_start_reg;
            end
        end
    end

    assign level_ext = {{LIDX_W{1'b0}}, level_reg};

    // Config registers and control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_res_reg     <= 24'd1000;
            high_res_reg    <= 24'd10000;
            tol_reg         <= 16'd3277;
            pos_start_reg   <= 15'sd1000;
            neg_start_reg   <= -15'sd1000;
            step_reg        <= 10'd50;
            max_amp_reg     <= 14'd3000;
            hits_needed_reg <= 16'd5;
            level_reg       <= '0;
            pos_amp_reg     <= 15'sd1000;
            neg_amp_reg     <= -15'sd1000;
            hit_reg         <= '0;
            fin_reg         <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_LOW_RES:   low_res_reg  <= cfg_data[RES_W-1:0];
                REG_HIGH_RES:  high_res_reg <= cfg_data[RES_W-1:0];
                REG_TOLERANCE: tol_reg      <= cfg_data[TOL_W-1:0];
                REG_POS_START: begin
                    pos_start_reg <= {1'b0, cfg_data[MAG_W-1:0]};
                    pos_amp_reg   <= {1'b0, cfg_data[MAG_W-1:0]};
                end
                REG_NEG_START: begin
                    neg_start_reg <= cfg_data[AMP_W-1:0];
                    neg_amp_reg   <= cfg_data[AMP_W-1:0];
                end
                REG_STEP:      step_reg        <= cfg_data[STEP_W-1:0];
                REG_MAX_AMP:   max_amp_reg     <= cfg_data[MAG_W-1:0];
                REG_HITS:      hits_needed_reg <= cfg_data[HIT_W-1:0];
                default: begin
                end
            endcase
        end else if (cmd.judge) begin
            level_reg   <= level_next;
            pos_amp_reg <= pos_amp_next;
            neg_amp_reg <= neg_amp_next;
            hit_reg     <= hit_next;
            fin_reg     <= fin_next;
        end
    end

    // Output register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.judge) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.judge) begin
            out_act_reg   <= act_next;
            out_pulse_reg <= pulse_next;
            out_lidx_reg  <= level_ext[LIDX_W-1:0];
            out_ldone_reg <= ldone_next;
            out_adone_reg <= adone_next;
        end
    end

    assign stat.finished = fin_reg;
    assign stat.out_free = !out_valid_reg || m_ready;

    assign m_valid       = out_valid_reg;
    assign m_action      = out_act_reg;
    assign m_pulse_mv    = out_pulse_reg;
    assign m_level_index = out_lidx_reg;
    assign m_level_done  = out_ldone_reg;
    assign m_all_done    = out_adone_reg;

endmodule
